>>> src/spq_pkg.sv
package spq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned PriorityWidth     = 8;
  localparam int unsigned PayloadWidth      = 16;
  localparam int unsigned OccupancyWidth    = 5;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdRemove = 2'd1,
    CmdClear  = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [PriorityWidth-1:0] in_priority;
    logic [PayloadWidth-1:0]  in_payload;
  } in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [PriorityWidth-1:0]  out_priority;
    logic [PayloadWidth-1:0]   out_payload;
    logic                      is_empty;
    logic [OccupancyWidth-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [PriorityWidth-1:0] priority_val;
    logic [PayloadWidth-1:0]  payload;
  } entry_t;

  // Shift commands broadcast to every cell of the row.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

>>> src/spq_cell.sv
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     new_entry_i,
  input  logic                occupied_i,
  input  logic                prev_keep_i,
  input  spq_pkg::entry_t     prev_entry_i,
  input  spq_pkg::entry_t     next_entry_i,
  output logic                keep_o,
  output spq_pkg::entry_t     entry_o
);

  spq_pkg::entry_t entry_d, entry_q;

  // An occupied cell whose priority is at least the new one stays put, so
  // equal priorities keep their arrival order.
  assign keep_o = occupied_i && (entry_q.priority_val >= new_entry_i.priority_val);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (prev_keep_i) begin
        entry_d = new_entry_i;
      end else begin
        entry_d = prev_entry_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> src/stable_priority_queue.sv
// Sorted priority queue built as a row of QueueDepth cells, head at cell 0.
// Every beat on the input channel carries one command (insert, remove the
// highest priority entry, clear or nop) and yields exactly one result beat the
// next cycle through an output register. All cells compare against the new
// priority in parallel and shift by one place in the same cycle, so the
// block accepts one command per clock cycle for as long as results are
// taken; the input stalls only while a finished result waits. Entries of
// equal priority leave in arrival order. Each result reports status, the
// removed entry (zero for other commands) and the fill level after the step.
module stable_priority_queue #(
  parameter int unsigned QueueDepth = spq_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_data_o
);

  localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

  logic [CountWidth-1:0] count_d, count_q;
  logic                  out_valid_d, out_valid_q;
  spq_pkg::out_t         out_d, out_q;

  logic                  accept;
  logic                  is_full;
  logic                  is_zero;
  spq_pkg::cell_ctrl_t   ctrl;
  spq_pkg::entry_t       new_entry;
  spq_pkg::entry_t       cell_entry [QueueDepth];
  logic [QueueDepth-1:0] cell_keep;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CountWidth'(QueueDepth));
  assign is_zero    = (count_q == '0);

  assign new_entry.priority_val = in_data_i.in_priority;
  assign new_entry.payload      = in_data_i.in_payload;

  assign ctrl.insert = accept && (in_data_i.cmd == spq_pkg::CmdInsert) && !is_full;
  assign ctrl.remove = accept && (in_data_i.cmd == spq_pkg::CmdRemove) && !is_zero;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic            prev_keep;
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_entry = new_entry;
    end else begin : g_body
      assign prev_keep  = cell_keep[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_entry_i  (new_entry),
      .occupied_i   (count_q > CountWidth'(i)),
      .prev_keep_i  (prev_keep),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .keep_o       (cell_keep[i]),
      .entry_o      (cell_entry[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    out_d      = '0;
    out_d.status = spq_pkg::StatusOk;
    case (spq_pkg::cmd_e'(in_data_i.cmd))
      spq_pkg::CmdInsert: begin
        if (is_full) begin
          out_d.status = spq_pkg::StatusFull;
        end else begin
          count_d = count_q + CountWidth'(1);
        end
      end
      spq_pkg::CmdRemove: begin
        if (is_zero) begin
          out_d.status = spq_pkg::StatusEmpty;
        end else begin
          count_d            = count_q - CountWidth'(1);
          out_d.out_priority = cell_entry[0].priority_val;
          out_d.out_payload  = cell_entry[0].payload;
        end
      end
      spq_pkg::CmdClear: begin
        if (is_zero) begin
          out_d.status = spq_pkg::StatusEmpty;
        end else begin
          count_d = '0;
        end
      end
      default: begin
      end
    endcase
    out_d.is_empty  = (count_d == '0);
    out_d.occupancy = spq_pkg::OccupancyWidth'(count_d);
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountWidth'(QueueDepth))
    else $error("entry count above queue depth");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted command gave no result");

  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == spq_pkg::StatusEmpty)) |-> out_data_o.is_empty)
    else $error("empty status with a nonempty queue");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> (count_q == $past(count_q) - CountWidth'(1)))
    else $error("remove did not drop the count by one");

endmodule
